// ===== rtl/core/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum
// Default sizes, register reset value and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int           WS_WIDTH = 7;
    localparam logic [6:0]   WS_RESET = 7'd3;

    // commands, controller -> datapath
    typedef struct packed {
        logic accept;     // latch request, apply first flag
        logic load_rd;    // read departing sample and queue front
        logic front_chk;  // drop front if it equals departing sample
        logic tail_rd;    // read queue tail
        logic tail_chk;   // drop tail if smaller than sample
        logic push;       // append sample, update history
        logic head_rd;    // read queue front for the result
        logic out_load;   // load result register
    } cmd_t;

    // status, datapath -> controller
    typedef struct packed {
        logic tail_pop;   // tail entry is smaller than sample
        logic full;       // window holds window_size samples
        logic out_free;   // result register can take a value
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl: sequencer for the sliding window maximum
// Steps one request through front check, tail pops, append and result.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire swm_pkg::status_t status,
    output swm_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FRONT,
        ST_TAIL_RD,
        ST_TAIL,
        ST_PUSH,
        ST_HEAD_RD,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load_rd = 1'b1;
                state_next  = ST_FRONT;
            end
            ST_FRONT: begin
                cmd.front_chk = 1'b1;
                state_next    = ST_TAIL_RD;
            end
            ST_TAIL_RD: begin
                cmd.tail_rd = 1'b1;
                state_next  = ST_TAIL;
            end
            ST_TAIL: begin
                cmd.tail_chk = 1'b1;
                state_next   = status.tail_pop ? ST_TAIL_RD : ST_PUSH;
            end
            ST_PUSH: begin
                cmd.push   = 1'b1;
                state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next  = status.full ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a result is only ever loaded from the emit step
    a_load_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (state_reg == ST_EMIT))
        else $error("result load outside emit step");

    // an accepted request always starts the sequence at the load step
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> (state_reg == ST_LOAD))
        else $error("accept did not start the sequence");

    // tail read is always followed by its check
    a_tail_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tail_rd |=> cmd.tail_chk)
        else $error("tail read without check");

endmodule

`default_nettype wire

// ===== rtl/core/swm_dp.sv =====
// ----------------------------------------------------------------------------
// swm_dp: datapath for the sliding window maximum
// Queue and history rings in memory, pointers, window register, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_dp #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [swm_pkg::WS_WIDTH-1:0]  cfg_wdata,
    input  wire logic signed [DATA_WIDTH-1:0]  s_sample,
    input  wire logic                          s_first,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]       m_window_max,
    input  wire swm_pkg::cmd_t                 cmd,
    output swm_pkg::status_t                   status
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int XW = CW + 1;

    // ring index wrap for sums below twice the depth
    function automatic logic [AW-1:0] wrap(input logic [XW-1:0] v);
        logic [XW-1:0] r;
        r = (v >= XW'(WINDOW_MAX)) ? (v - XW'(WINDOW_MAX)) : v;
        return AW'(r);
    endfunction

    logic signed [DATA_WIDTH-1:0] qmem [WINDOW_MAX];
    logic signed [DATA_WIDTH-1:0] hmem [WINDOW_MAX];

    logic [swm_pkg::WS_WIDTH-1:0] ws_reg;
    logic signed [DATA_WIDTH-1:0] sample_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                fill_reg;
    logic [AW-1:0]                head_reg;
    logic [AW-1:0]                hptr_reg;
    logic signed [DATA_WIDTH-1:0] q_rd_reg;
    logic signed [DATA_WIDTH-1:0] h_rd_reg;
    logic                         m_valid_reg;
    logic signed [DATA_WIDTH-1:0] m_window_max_reg;

    logic [XW-1:0] w_eff;
    logic [XW-1:0] hptr_x;
    logic [AW-1:0] leave_idx;
    logic [AW-1:0] tail_idx;
    logic [AW-1:0] q_rd_addr;
    logic          q_rd_en;
    logic          drop;
    logic [CW-1:0] count_kept;
    logic [AW-1:0] head_kept;
    logic [AW-1:0] put_idx;
    logic          full;
    logic          front_pop;

    // window size zero counts as one, above the depth as the depth
    always_comb begin
        if (ws_reg == '0) begin
            w_eff = XW'(1);
        end else if (32'(ws_reg) > 32'(WINDOW_MAX)) begin
            w_eff = XW'(WINDOW_MAX);
        end else begin
            w_eff = XW'(ws_reg);
        end
    end

    assign full   = XW'(fill_reg) >= w_eff;
    assign hptr_x = XW'(hptr_reg);

    always_comb begin
        if (hptr_x >= w_eff) begin
            leave_idx = AW'(hptr_x - w_eff);
        end else begin
            leave_idx = AW'(hptr_x + XW'(WINDOW_MAX) - w_eff);
        end
    end

    assign tail_idx   = wrap(XW'(head_reg) + XW'(count_reg) - XW'(1));
    assign front_pop  = full && (count_reg != '0) && (q_rd_reg == h_rd_reg);

    // queue full on append: oldest entry goes first
    assign drop       = count_reg == CW'(WINDOW_MAX);
    assign count_kept = drop ? (count_reg - CW'(1)) : count_reg;
    assign head_kept  = drop ? wrap(XW'(head_reg) + XW'(1)) : head_reg;
    assign put_idx    = wrap(XW'(head_kept) + XW'(count_kept));

    always_comb begin
        q_rd_en   = cmd.load_rd || cmd.head_rd || (cmd.tail_rd && (count_reg != '0));
        q_rd_addr = cmd.tail_rd ? tail_idx : head_reg;
    end

    assign status.tail_pop = (count_reg != '0) && (sample_reg > q_rd_reg);
    assign status.full     = full;
    assign status.out_free = !m_valid_reg || m_ready;

    // memories
    always_ff @(posedge aclk) begin
        if (q_rd_en) begin
            q_rd_reg <= qmem[q_rd_addr];
        end
        if (cmd.push) begin
            qmem[put_idx] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_rd) begin
            h_rd_reg <= hmem[leave_idx];
        end
        if (cmd.push) begin
            hmem[hptr_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= s_sample;
        end
        if (cmd.out_load) begin
            m_window_max_reg <= q_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg      <= swm_pkg::WS_RESET;
            count_reg   <= '0;
            fill_reg    <= '0;
            head_reg    <= '0;
            hptr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                ws_reg <= cfg_wdata;
            end
            if (cmd.accept && s_first) begin
                count_reg <= '0;
                fill_reg  <= '0;
                hptr_reg  <= '0;
            end
            if (cmd.front_chk && front_pop) begin
                head_reg  <= wrap(XW'(head_reg) + XW'(1));
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.tail_chk && status.tail_pop) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.push) begin
                head_reg  <= head_kept;
                count_reg <= count_kept + CW'(1);
                hptr_reg  <= wrap(XW'(hptr_reg) + XW'(1));
                if (fill_reg < CW'(WINDOW_MAX)) begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_window_max = m_window_max_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CW'(WINDOW_MAX)) && (fill_reg <= CW'(WINDOW_MAX)))
        else $error("queue or fill count beyond depth");

    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> (count_reg != '0))
        else $error("queue empty after append");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_max_top.sv =====
// One request at a time: s_ready is high only in the idle step, so a new request is taken
//   only after the last has finished; tail pops are paced by the single read port of the
//   queue memory, one tail compare per read.
// A result waiting in the output register stalls the next request at its emit step.
// Reset (aresetn, synchronous, active low): queue and fill counts, pointers cleared,
//   window_size back to 3; memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// sliding_window_max_top: streaming running maximum over a sliding window
// Monotonic deque of candidate maxima plus a ring of recent samples.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_top #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration: window_size
    input  wire logic                          cfg_we,
    input  wire logic [swm_pkg::WS_WIDTH-1:0]  cfg_wdata,
    // sample requests
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [DATA_WIDTH-1:0]  s_sample,
    input  wire logic                          s_first,
    // window maximum results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]       m_window_max
);

    // Sequence per request:
    //   idle    - take request; first flag clears queue, fill count, history pointer
    //   load    - read departing sample and queue front
    //   front   - drop front if equal to departing sample (window full only)
    //   tail    - read/compare tail, drop while strictly smaller
    //   push    - append sample, write history, bump pointers
    //   head_rd - read new front; window full gives a result
    //   emit    - hand result to output register once it is free

    swm_pkg::cmd_t    cmd;
    swm_pkg::status_t status;

    swm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swm_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_sample     (s_sample),
        .s_first      (s_first),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_window_max (m_window_max),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire
